FILE: rtl/kmer_minimizer_selector_core_defines.svh
// Assertion macros shared by the checker of the k-mer minimizer selector.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef KMER_MINIMIZER_SELECTOR_CORE_DEFINES_SVH
`define KMER_MINIMIZER_SELECTOR_CORE_DEFINES_SVH

// antecedent in this cycle, consequent in the next
`define KMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent and consequent in the same cycle
`define KMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kms_pkg.sv
// Shared constants and types of the k-mer minimizer selector.
// No dependencies; imported by every module of the block.
package kms_pkg;

    localparam int HASH_W      = 64;
    localparam int KLEN_W      = 6;
    localparam int WLEN_W      = 7;
    localparam int CFG_W       = 7;
    localparam int OUT_POS_W   = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 96;
    localparam int KMER_MAX    = 32;

    // configuration register indexes
    localparam logic CFG_KMER_LEN   = 1'b0;
    localparam logic CFG_WINDOW_LEN = 1'b1;

    // shift amounts of the mixing hash
    localparam int HSH_SH_A = 21;
    localparam int HSH_SH_B = 24;
    localparam int HSH_SH_C = 3;
    localparam int HSH_SH_D = 8;
    localparam int HSH_SH_E = 14;
    localparam int HSH_SH_F = 2;
    localparam int HSH_SH_G = 4;
    localparam int HSH_SH_H = 28;
    localparam int HSH_SH_I = 31;

    // queue operation broadcast to every cell
    typedef struct packed {
        logic clear;   // drop all entries
        logic ins;     // cut entries with hash >= new, append new
        logic pop;     // shift toward head by one
        logic full;    // all cells survive the cut: drop head on insert
    } cell_ctl_t;

endpackage

FILE: rtl/kmer_minimizer_selector_core.sv
// Sliding-window k-mer minimizer selector: one base per input beat (tdata[1:0]),
// tuser starts a new sequence, tlast marks its final base. A base that completes
// no k-mer is taken in idle and the block stays ready. A base that completes a
// k-mer is taken in idle, passes the hash pipeline, is handed over, then goes
// through the parallel compare-and-append across the row of MAX_WINDOW cells and
// the emit decision; before that decision the head of the row shifts out one
// expired entry per cycle. A result beat (position in tdata[31:0], hash in
// tdata[95:32]) leaves through an output register, so the next base is taken while
// it waits; a further result holds the block until that register frees.
// No clearing pass after reset.
module kmer_minimizer_selector_core #(
    parameter int MAX_WINDOW = 64,
    parameter int POS_BITS   = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [kms_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [kms_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // base_code[1:0], zero pad
    input  logic                            s_axis_tuser,  // first_base
    input  logic                            s_axis_tlast,  // last_base
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [kms_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // minimizer_pos[31:0],
                                                           // minimizer_hash[95:32]
);
    import kms_pkg::*;

    localparam int WM1_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PE_W  = POS_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HASH = 4'b0010,
        S_INS  = 4'b0100,
        S_POP  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [KLEN_W-1:0]    kmer_len_reg;
    logic [WLEN_W-1:0]    window_len_reg;
    logic [HASH_W-1:0]    kmer_shift_reg, kmer_shift_next;
    logic [POS_BITS-1:0]  base_count_reg, base_count_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [HASH_W-1:0]    mask_reg, mask_next;
    logic                 last_reg, last_next;
    logic                 hstart_reg, hstart_next;
    logic [POS_BITS-1:0]  last_emitted_reg, last_emitted_next;
    logic                 emitted_any_reg, emitted_any_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_POS_W-1:0] m_pos_reg;
    logic [HASH_W-1:0]    m_hash_reg;
    logic                 out_load;

    logic                 accept;
    logic [KLEN_W-1:0]    k_eff;
    logic [8:0]           wl9;
    logic [WM1_W-1:0]     wm1;
    logic [HASH_W-1:0]    mask_cur;
    logic [HASH_W-1:0]    shift_base, kmer_new;
    logic [POS_BITS-1:0]  count_base, count_new;
    logic                 head_expired;
    logic                 do_emit;
    logic                 dup;

    logic                 hash_done;
    logic [HASH_W-1:0]    new_hash;
    cell_ctl_t            ctl;

    logic [MAX_WINDOW-1:0] cell_valid;
    logic [MAX_WINDOW-1:0] cell_live;
    logic [POS_BITS-1:0]   cell_pos  [MAX_WINDOW];
    logic [HASH_W-1:0]     cell_hash [MAX_WINDOW];

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // register clamps
    always_comb
    begin
        if (kmer_len_reg == '0)
        begin
            k_eff = KLEN_W'(1);
        end
        else if (kmer_len_reg > KLEN_W'(KMER_MAX))
        begin
            k_eff = KLEN_W'(KMER_MAX);
        end
        else
        begin
            k_eff = kmer_len_reg;
        end
        wl9 = {2'b00, window_len_reg};
        if (wl9 == 9'd0)
        begin
            wl9 = 9'd1;
        end
        else if (wl9 > 9'(MAX_WINDOW))
        begin
            wl9 = 9'(MAX_WINDOW);
        end
        wm1 = WM1_W'(wl9 - 9'd1);
    end

    assign mask_cur   = {HASH_W{1'b1}} >> (7'd64 - {k_eff, 1'b0});
    assign shift_base = s_axis_tuser ? '0 : kmer_shift_reg;
    assign count_base = s_axis_tuser ? '0 : base_count_reg;
    assign kmer_new   = ((shift_base << 2) | HASH_W'(s_axis_tdata[1:0])) & mask_cur;
    assign count_new  = (&count_base) ? count_base : count_base + POS_BITS'(1);

    assign head_expired = cell_valid[0]
                       && (({1'b0, cell_pos[0]} + PE_W'(wm1)) < {1'b0, pos_reg});
    assign do_emit      = (pos_reg >= POS_BITS'(wm1)) || last_reg;
    assign dup          = emitted_any_reg && (cell_pos[0] == last_emitted_reg);

    always_comb
    begin
        state_next        = state_reg;
        kmer_shift_next   = kmer_shift_reg;
        base_count_next   = base_count_reg;
        pos_next          = pos_reg;
        mask_next         = mask_reg;
        last_next         = last_reg;
        hstart_next       = 1'b0;
        last_emitted_next = last_emitted_reg;
        emitted_any_next  = emitted_any_reg;
        out_load          = 1'b0;
        ctl               = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl.clear       = s_axis_tuser;
                    kmer_shift_next = kmer_new;
                    base_count_next = count_new;
                    mask_next       = mask_cur;
                    last_next       = s_axis_tlast;
                    if (s_axis_tuser)
                    begin
                        last_emitted_next = '0;
                        emitted_any_next  = 1'b0;
                    end
                    if (count_new >= POS_BITS'(k_eff))
                    begin
                        pos_next    = count_new - POS_BITS'(k_eff);
                        hstart_next = 1'b1;
                        state_next  = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                ctl.ins    = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (head_expired)
                begin
                    ctl.pop = 1'b1;
                end
                else if (do_emit && !dup)
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        out_load          = 1'b1;
                        last_emitted_next = cell_pos[0];
                        emitted_any_next  = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ctl.full = cell_live[MAX_WINDOW-1];
    end

    assign m_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            kmer_len_reg     <= KLEN_W'(15);
            window_len_reg   <= WLEN_W'(10);
            kmer_shift_reg   <= '0;
            base_count_reg   <= '0;
            hstart_reg       <= 1'b0;
            last_emitted_reg <= '0;
            emitted_any_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            kmer_shift_reg   <= kmer_shift_next;
            base_count_reg   <= base_count_next;
            hstart_reg       <= hstart_next;
            last_emitted_reg <= last_emitted_next;
            emitted_any_reg  <= emitted_any_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KMER_LEN:   kmer_len_reg   <= cfg_data[KLEN_W-1:0];
                    CFG_WINDOW_LEN: window_len_reg <= cfg_data[WLEN_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        mask_reg  <= mask_next;
        last_reg  <= last_next;
        if (out_load)
        begin
            m_pos_reg  <= OUT_POS_W'(cell_pos[0]);
            m_hash_reg <= cell_hash[0];
        end
    end

    kms_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hstart_reg),
        .key   (kmer_shift_reg),
        .mask  (mask_reg),
        .done  (hash_done),
        .hash  (new_hash)
    );

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic                left_live;
        logic                nbr_valid;
        logic [POS_BITS-1:0] nbr_pos;
        logic [HASH_W-1:0]   nbr_hash;

        if (i == 0)
        begin : g_head
            assign left_live = 1'b1;
        end
        else
        begin : g_body
            assign left_live = cell_live[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_tail
            // full insert brings the new entry in from the tail side
            assign nbr_valid = ctl.ins;
            assign nbr_pos   = pos_reg;
            assign nbr_hash  = new_hash;
        end
        else
        begin : g_link
            assign nbr_valid = cell_valid[i+1];
            assign nbr_pos   = cell_pos[i+1];
            assign nbr_hash  = cell_hash[i+1];
        end

        kms_cell #(
            .POS_BITS (POS_BITS)
        ) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .new_pos   (pos_reg),
            .new_hash  (new_hash),
            .left_live (left_live),
            .nbr_valid (nbr_valid),
            .nbr_pos   (nbr_pos),
            .nbr_hash  (nbr_hash),
            .valid     (cell_valid[i]),
            .pos       (cell_pos[i]),
            .hash      (cell_hash[i]),
            .live      (cell_live[i])
        );
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_hash_reg, m_pos_reg};

endmodule

FILE: rtl/kms_hash.sv
// Four-stage shift-add-xor hash of one k-mer, masked to 2k bits.
// Depends on kms_pkg.
module kms_hash
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [kms_pkg::HASH_W-1:0] key,
    input  logic [kms_pkg::HASH_W-1:0] mask,
    output logic                      done,
    output logic [kms_pkg::HASH_W-1:0] hash
);
    import kms_pkg::*;

    logic [3:0]        vld_reg;
    logic [3:0]        vld_next;
    logic [HASH_W-1:0] s1_reg, s2_reg, s3_reg, s4_reg;
    logic [HASH_W-1:0] s1_next, s2_next, s3_next, s4_next;
    logic [HASH_W-1:0] b, d, f;

    always_comb
    begin
        vld_next = {vld_reg[2:0], start};
        s1_next  = (~key + (key << HSH_SH_A)) & mask;
        b        = s1_reg ^ (s1_reg >> HSH_SH_B);
        s2_next  = (b + (b << HSH_SH_C) + (b << HSH_SH_D)) & mask;
        d        = s2_reg ^ (s2_reg >> HSH_SH_E);
        s3_next  = (d + (d << HSH_SH_F) + (d << HSH_SH_G)) & mask;
        f        = s3_reg ^ (s3_reg >> HSH_SH_H);
        s4_next  = (f + (f << HSH_SH_I)) & mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_next[0])
        begin
            s1_reg <= s1_next;
        end
        if (vld_next[1])
        begin
            s2_reg <= s2_next;
        end
        if (vld_next[2])
        begin
            s3_reg <= s3_next;
        end
        if (vld_next[3])
        begin
            s4_reg <= s4_next;
        end
    end

    assign done = vld_reg[3];
    assign hash = s4_reg;

endmodule

FILE: rtl/kms_cell.sv
// One entry of the monotone window queue; cells form a row, head at cell 0.
// Depends on kms_pkg.
module kms_cell #(
    parameter int POS_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  kms_pkg::cell_ctl_t         ctl,
    input  logic [POS_BITS-1:0]        new_pos,
    input  logic [kms_pkg::HASH_W-1:0] new_hash,
    input  logic                       left_live,
    input  logic                       nbr_valid,
    input  logic [POS_BITS-1:0]        nbr_pos,
    input  logic [kms_pkg::HASH_W-1:0] nbr_hash,
    output logic                       valid,
    output logic [POS_BITS-1:0]        pos,
    output logic [kms_pkg::HASH_W-1:0] hash,
    output logic                       live
);
    import kms_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [POS_BITS-1:0] pos_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic                ld;
    logic [POS_BITS-1:0] src_pos;
    logic [HASH_W-1:0]   src_hash;

    // survives the cut of a new hash
    assign live = valid_reg && (new_hash > hash_reg);

    always_comb
    begin
        valid_next = valid_reg;
        ld         = 1'b0;
        src_pos    = nbr_pos;
        src_hash   = nbr_hash;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.pop || (ctl.ins && ctl.full))
        begin
            valid_next = nbr_valid;
            ld         = 1'b1;
        end
        else if (ctl.ins)
        begin
            if (!live && left_live)
            begin
                valid_next = 1'b1;
                ld         = 1'b1;
                src_pos    = new_pos;
                src_hash   = new_hash;
            end
            else
            begin
                valid_next = live;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            pos_reg  <= src_pos;
            hash_reg <= src_hash;
        end
    end

    assign valid = valid_reg;
    assign pos   = pos_reg;
    assign hash  = hash_reg;

endmodule

FILE: rtl/kms_checker.sv
// Port-level checks of the k-mer minimizer selector, bound to its top level.
// Depends on kms_pkg and kmer_minimizer_selector_core_defines.svh.
`include "kmer_minimizer_selector_core_defines.svh"

module kms_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [kms_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    `KMS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")
    `KMS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "stalled result changed")
    `KMS_ASSERT_NEXT(a_no_instant, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result too soon after a base beat")
    `KMS_ASSERT_NOW(a_rise_busy, $rose(m_axis_tvalid), $past(!s_axis_tready), "result raised while idle")

endmodule

bind kmer_minimizer_selector_core kms_checker u_kms_checker (.*);

FILE: dv/kms_minimizer_checker.sv
// Scoreboard for kmer_minimizer_selector_core: tracks config writes and base beats,
// predicts minimizer beats and compares them against the output channel.
// Depends on kms_pkg.
`timescale 1ns / 100ps

module kms_minimizer_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [kms_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [kms_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [kms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int unsigned                     mismatch_count,
    output int unsigned                     minimizers_pending
);

    localparam int QDEPTH    = 64;
    localparam int DUE_DEPTH = 64;

    typedef struct packed {
        logic [31:0] pos;
        logic [63:0] hash;
    } minimizer_t;

    logic [kms_pkg::KLEN_W-1:0] kmer_len_r;
    logic [kms_pkg::WLEN_W-1:0] window_len_r;
    logic [63:0]                kmer_bits;
    logic [31:0]                base_cnt;
    logic [31:0]                cand_pos [QDEPTH];
    logic [63:0]                cand_hash [QDEPTH];
    logic [5:0]                 cand_head;
    logic [6:0]                 cand_fill;
    logic [31:0]                prev_pos;
    logic                       prev_valid;
    minimizer_t                 due_mem [DUE_DEPTH];
    logic [5:0]                 due_rd;
    logic [5:0]                 due_wr;
    int unsigned                due_cnt;
    int unsigned                fails;

    function automatic logic [63:0] mix_key(input logic [63:0] key, input logic [63:0] m);
        key = (~key + (key << 21)) & m;
        key = key ^ (key >> 24);
        key = (key + (key << 3) + (key << 8)) & m;
        key = key ^ (key >> 14);
        key = (key + (key << 2) + (key << 4)) & m;
        key = key ^ (key >> 28);
        key = (key + (key << 31)) & m;
        return key;
    endfunction

    task automatic clear_sequence();
        kmer_bits  = '0;
        base_cnt   = '0;
        cand_head  = '0;
        cand_fill  = '0;
        prev_pos   = '0;
        prev_valid = 1'b0;
    endtask

    task automatic absorb_base(input logic [1:0] code, input logic first, input logic last);
        int unsigned k;
        int unsigned w;
        logic [63:0] mask;
        logic [63:0] h;
        logic [31:0] pos;
        logic [5:0]  s;
        logic        emit;
        if (first)
            clear_sequence();
        k = kmer_len_r;
        w = window_len_r;
        if (k < 1) k = 1;
        if (k > 32) k = 32;
        if (w < 1) w = 1;
        if (w > QDEPTH) w = QDEPTH;
        mask = (k >= 32) ? {64{1'b1}} : ((64'd1 << (2 * k)) - 64'd1);
        kmer_bits = ((kmer_bits << 2) | {62'd0, code}) & mask;
        if (base_cnt != 32'hFFFF_FFFF)
            base_cnt = base_cnt + 32'd1;
        if (base_cnt < k)
            return;
        pos = base_cnt - k;
        h = mix_key(kmer_bits, mask);
        while (cand_fill > 0 && h <= cand_hash[cand_head + 6'(cand_fill - 7'd1)])
            cand_fill = cand_fill - 7'd1;
        if (cand_fill >= QDEPTH)
        begin
            cand_head = cand_head + 6'd1;
            cand_fill = cand_fill - 7'd1;
        end
        s = cand_head + 6'(cand_fill);
        cand_pos[s]  = pos;
        cand_hash[s] = h;
        cand_fill    = cand_fill + 7'd1;
        while (cand_fill > 0 && 64'(cand_pos[cand_head]) + w - 1 < 64'(pos))
        begin
            cand_head = cand_head + 6'd1;
            cand_fill = cand_fill - 7'd1;
        end
        emit = (64'(pos) + 1 >= w) || last;
        if (!emit)
            return;
        if (prev_valid && cand_pos[cand_head] == prev_pos)
            return;
        prev_pos   = cand_pos[cand_head];
        prev_valid = 1'b1;
        if (due_cnt >= DUE_DEPTH)
        begin
            $display("%0t: too many minimizers outstanding: expected at most %0d, got %0d",
                     $time, DUE_DEPTH, due_cnt + 1);
            fails++;
        end
        else
        begin
            due_mem[due_wr] = '{pos: prev_pos, hash: cand_hash[cand_head]};
            due_wr          = due_wr + 6'd1;
            due_cnt         = due_cnt + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        minimizer_t exp_min;
        if (!rst_n)
        begin
            kmer_len_r   = 6'd15;
            window_len_r = 7'd10;
            clear_sequence();
            due_rd  = '0;
            due_wr  = '0;
            due_cnt = 0;
            fails   = 0;
        end
        else
        begin
            // results leave before this edge's base can produce anything
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_cnt == 0)
                begin
                    $display("%0t: unexpected minimizer beat: expected none, got pos %0d hash %h",
                             $time, m_axis_tdata[31:0], m_axis_tdata[95:32]);
                    fails++;
                end
                else
                begin
                    exp_min = due_mem[due_rd];
                    due_rd  = due_rd + 6'd1;
                    due_cnt = due_cnt - 1;
                    if (m_axis_tdata[31:0] !== exp_min.pos)
                    begin
                        $display("%0t: minimizer_pos mismatch: expected %0d, got %0d",
                                 $time, exp_min.pos, m_axis_tdata[31:0]);
                        fails++;
                    end
                    if (m_axis_tdata[95:32] !== exp_min.hash)
                    begin
                        $display("%0t: minimizer_hash mismatch: expected %h, got %h",
                                 $time, exp_min.hash, m_axis_tdata[95:32]);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_base(s_axis_tdata[1:0], s_axis_tuser, s_axis_tlast);
            if (cfg_we)
            begin
                if (cfg_index == kms_pkg::CFG_KMER_LEN)
                    kmer_len_r = cfg_data[kms_pkg::KLEN_W-1:0];
                else
                    window_len_r = cfg_data[kms_pkg::WLEN_W-1:0];
            end
        end
        mismatch_count     <= fails;
        minimizers_pending <= due_cnt;
    end

endmodule

FILE: dv/tb_top.sv
// Top of the kmer_minimizer_selector_core testbench: clock, reset, base stimulus,
// config phases and output back-pressure. Depends on kms_pkg and kms_minimizer_checker.
`timescale 1ns / 100ps

module tb_top;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic                            cfg_index = kms_pkg::CFG_KMER_LEN;
    logic [kms_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [kms_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tuser = 1'b0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [kms_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    int unsigned                     mismatch_count;
    int unsigned                     minimizers_pending;
    logic                            idle_on = 1'b1;
    int                              stall_left = 0;
    int                              cur_k;
    int                              cur_w;

    kmer_minimizer_selector_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    kms_minimizer_checker i_checker
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .s_axis_tuser       (s_axis_tuser),
        .s_axis_tlast       (s_axis_tlast),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .mismatch_count     (mismatch_count),
        .minimizers_pending (minimizers_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output back-pressure in bursts while idle_on is set; always ready once it is cleared
    always @(posedge clk)
    begin
        if (!idle_on)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

    task automatic set_config(input logic [6:0] k_raw, input logic [6:0] w_raw);
        cfg_we    <= 1'b1;
        cfg_index <= kms_pkg::CFG_KMER_LEN;
        cfg_data  <= k_raw;
        @(posedge clk);
        cfg_index <= kms_pkg::CFG_WINDOW_LEN;
        cfg_data  <= w_raw;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_k = k_raw[5:0];
        cur_w = w_raw;
        if (cur_k < 1) cur_k = 1;
        if (cur_k > 32) cur_k = 32;
        if (cur_w < 1) cur_w = 1;
        if (cur_w > 64) cur_w = 64;
    endtask

    task automatic send_base(input logic [1:0] code, input logic first, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, code};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // hold off until every minimizer is out and the pipeline has drained
    task automatic end_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (minimizers_pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic run_phase(input int n_items, input logic fresh);
        int         sent;
        int         len;
        int         mode;
        logic [1:0] pat_a;
        logic [1:0] pat_b;
        logic [1:0] code;
        logic       first;
        logic       last;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, cur_k + 2);
            else
                len = $urandom_range(cur_k, cur_k + cur_w + 24);
            mode  = $urandom_range(0, 5);
            pat_a = 2'($urandom);
            pat_b = 2'($urandom);
            for (int i = 0; i < len; i++)
            begin
                case (mode)
                    0:       code = pat_a;
                    1:       code = i[0] ? pat_b : pat_a;
                    default: code = 2'($urandom);
                endcase
                first = (i == 0) && (fresh || sent > 0);
                last  = (i == len - 1);
                if ($urandom_range(0, 19) == 0)
                begin
                    first = 1'($urandom);
                    last  = 1'($urandom);
                end
                send_base(code, first, last);
            end
            sent += len;
        end
    endtask

    initial
    begin
        logic [6:0] phase_k [12];
        logic [6:0] phase_w [12];
        int         n;
        phase_k = '{7'h7F, 7'd32, 7'd2, 7'd5, 7'd15, 7'd1, 7'd32, 7'd21, 7'd4, 7'd0,
                    7'd12, 7'd3};
        phase_w = '{7'h7F, 7'd64, 7'd3, 7'd8, 7'd10, 7'd64, 7'd1, 7'd16, 7'd2, 7'd65,
                    7'd33, 7'd5};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every k-mer is its own window
        set_config(7'd1, 7'd1);
        send_base(2'd0, 1'b1, 1'b0);
        send_base(2'd1, 1'b0, 1'b0);
        send_base(2'd2, 1'b0, 1'b0);
        send_base(2'd3, 1'b0, 1'b0);
        send_base(2'd3, 1'b0, 1'b1);
        end_phase();

        // short sequences, some with no complete k-mer, continuing after last
        set_config(7'd3, 7'd10);
        send_base(2'd3, 1'b1, 1'b0);
        send_base(2'd2, 1'b0, 1'b0);
        send_base(2'd1, 1'b0, 1'b0);
        send_base(2'd0, 1'b0, 1'b0);
        send_base(2'd1, 1'b0, 1'b1);
        send_base(2'd2, 1'b1, 1'b0);
        send_base(2'd0, 1'b0, 1'b1);
        send_base(2'd1, 1'b0, 1'b0);
        send_base(2'd1, 1'b0, 1'b0);
        send_base(2'd1, 1'b0, 1'b1);
        send_base(2'd0, 1'b1, 1'b1);
        end_phase();

        // zero registers act as one; equal hashes
        set_config(7'd0, 7'd0);
        send_base(2'd2, 1'b1, 1'b0);
        send_base(2'd2, 1'b0, 1'b0);
        send_base(2'd2, 1'b0, 1'b1);
        end_phase();

        for (int p = 0; p < 12; p++)
        begin
            if (p == 10)
                idle_on <= 1'b0;
            set_config(phase_k[p], phase_w[p]);
            n = 26;
            // a phase may carry the previous sequence across the register change
            run_phase(n, (p == 0) || ($urandom_range(0, 2) != 0));
            end_phase();
        end

        if (mismatch_count == 0 && minimizers_pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
